### src/mspd_pkg.sv
// ----------------------------------------------------------------------------
// mspd_pkg: shared types and constants
// Request codes, register indexes, reset values, and controller/datapath
// command and status structures for the mass-scaled joint PD core.
// ----------------------------------------------------------------------------
package mspd_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 31;
  localparam int FRAME_W   = 20;
  localparam int JCNT_W    = 7;
  localparam int JIDX_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 66;
  localparam int ACC_W     = 56;
  localparam int FRAC_BITS = 16;

  localparam logic [GAIN_W-1:0]  KP_RESET     = 31'd52428800;
  localparam logic [GAIN_W-1:0]  KD_RESET     = 31'd983040;
  localparam logic [DATA_W-1:0]  FPS_RESET    = 32'd65536;
  localparam logic [FRAME_W-1:0] FINAL_RESET  = 20'd0;
  localparam logic [JCNT_W-1:0]  ACTIVE_RESET = 7'd32;

  localparam logic [1:0] REQ_MASS    = 2'd0;
  localparam logic [1:0] REQ_JOINT   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd4;

  typedef enum logic [1:0] {
    MUL_FRAME = 2'd0,
    MUL_KP    = 2'd1,
    MUL_KD    = 2'd2,
    MUL_MAC   = 2'd3
  } mul_sel_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_FRAME = 10'b0000000010,
    ST_CLAMP = 10'b0000000100,
    ST_JP    = 10'b0000001000,
    ST_JD    = 10'b0000010000,
    ST_JSUM  = 10'b0000100000,
    ST_ISSUE = 10'b0001000000,
    ST_DRAIN = 10'b0010000000,
    ST_EMIT  = 10'b0100000000,
    ST_ACK   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic     cap;
    mul_sel_e mul_sel;
    logic     frame_ld;
    logic     mass_we;
    logic     p_ld;
    logic     pd_we;
    logic     mac_issue;
    logic     acc_clr;
    logic     out_load;
    logic     out_ack;
    logic     out_last;
    logic     step_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              row_ok;
    logic              mass_ok;
    logic              mac_busy;
    logic              out_free;
    logic [JCNT_W-1:0] joint_count;
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] x);
    sat_t r;
    if (x > 66'sh0_7FFF_FFFF) begin
      r.val  = 32'h7FFF_FFFF;
      r.clip = 1'b1;
    end else if (x < -66'sh0_8000_0000) begin
      r.val  = 32'h8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = x[DATA_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

### src/mspd_req_if.sv
// ----------------------------------------------------------------------------
// mspd_req_if: request channel
// Valid/ready channel carrying one load or compute request.
// ----------------------------------------------------------------------------
interface mspd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  row_index;
  logic [5:0]  col_index;
  logic [31:0] mass_value;
  logic [31:0] joint_position;
  logic [31:0] joint_velocity;
  logic [31:0] target_position;

  modport source (
    output valid, req_type, row_index, col_index, mass_value,
           joint_position, joint_velocity, target_position,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, col_index, mass_value,
           joint_position, joint_velocity, target_position,
    output ready
  );
endinterface

### src/mspd_rsp_if.sv
// ----------------------------------------------------------------------------
// mspd_rsp_if: response channel
// Valid/ready channel carrying one torque or acknowledge.
// ----------------------------------------------------------------------------
interface mspd_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  joint_index;
  logic [31:0] torque;
  logic [19:0] motion_frame;
  logic        saturated;
  logic        is_last;

  modport source (
    output valid, joint_index, torque, motion_frame, saturated, is_last,
    input  ready
  );
  modport sink (
    input  valid, joint_index, torque, motion_frame, saturated, is_last,
    output ready
  );
endinterface

### src/mspd_ctrl.sv
// ----------------------------------------------------------------------------
// mspd_ctrl: sequencer
// One-hot state machine that walks each request through frame lookup,
// mass write, PD update or the row-by-row multiply-accumulate over the matrix.
// ----------------------------------------------------------------------------
module mspd_ctrl #(
  parameter int NDOF = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  mspd_pkg::status_t                      status_i,
  output mspd_pkg::cmd_t                         cmd_o,
  output logic [((NDOF > 1) ? $clog2(NDOF) : 1)-1:0] mac_row_o,
  output logic [((NDOF > 1) ? $clog2(NDOF) : 1)-1:0] mac_col_o
);
  import mspd_pkg::*;

  localparam int IDX_W = (NDOF > 1) ? $clog2(NDOF) : 1;

  state_e            state_q, state_d;
  logic [JCNT_W-1:0] row_q, row_d;
  logic [JCNT_W-1:0] col_q, col_d;
  logic [JCNT_W-1:0] n_last;

  assign n_last     = status_i.joint_count - 7'd1;
  assign in_ready_o = (state_q == ST_IDLE);
  assign mac_row_o  = row_q[IDX_W-1:0];
  assign mac_col_o  = col_q[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_MAC;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_FRAME;
        end
      end
      ST_FRAME: begin
        cmd_o.mul_sel = MUL_FRAME;
        state_d       = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.frame_ld = 1'b1;
        case (status_i.req_type)
          REQ_MASS: begin
            cmd_o.mass_we = status_i.mass_ok;
            state_d       = ST_ACK;
          end
          REQ_JOINT: begin
            state_d = status_i.row_ok ? ST_JP : ST_ACK;
          end
          REQ_COMPUTE: begin
            cmd_o.acc_clr = 1'b1;
            row_d         = '0;
            col_d         = '0;
            state_d       = ST_ISSUE;
          end
          default: state_d = ST_ACK;
        endcase
      end
      ST_JP: begin
        cmd_o.mul_sel = MUL_KP;
        state_d       = ST_JD;
      end
      ST_JD: begin
        cmd_o.mul_sel = MUL_KD;
        cmd_o.p_ld    = 1'b1;
        state_d       = ST_JSUM;
      end
      ST_JSUM: begin
        cmd_o.pd_we = 1'b1;
        state_d     = ST_ACK;
      end
      ST_ISSUE: begin
        cmd_o.mac_issue = 1'b1;
        col_d           = col_q + 7'd1;
        if (col_q == n_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!status_i.mac_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (row_q == n_last);
          if (row_q == n_last) begin
            cmd_o.step_inc = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.acc_clr = 1'b1;
            row_d         = row_q + 7'd1;
            col_d         = '0;
            state_d       = ST_ISSUE;
          end
        end
      end
      ST_ACK: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ack  = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded while output register is occupied");

  a_step_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_inc |-> (cmd_o.out_load && cmd_o.out_last && !cmd_o.out_ack))
    else $error("step advanced away from the last torque");

  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_issue |=> status_i.mac_busy)
    else $error("issued multiply-accumulate not tracked");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !status_i.mac_busy)
    else $error("torque emitted before accumulation finished");

endmodule

### src/mspd_dpath.sv
// ----------------------------------------------------------------------------
// mspd_dpath: datapath
// Configuration registers, request capture, mass and PD memories, shared
// 33x33 multiplier, accumulator, step counter and output register.
// ----------------------------------------------------------------------------
module mspd_dpath #(
  parameter int NDOF      = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mspd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [31:0]                            cfg_wdata_i,
  input  logic [1:0]                             req_type_i,
  input  logic [5:0]                             row_index_i,
  input  logic [5:0]                             col_index_i,
  input  logic [31:0]                            mass_value_i,
  input  logic [31:0]                            joint_position_i,
  input  logic [31:0]                            joint_velocity_i,
  input  logic [31:0]                            target_position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [5:0]                             joint_index_o,
  output logic [31:0]                            torque_o,
  output logic [19:0]                            motion_frame_o,
  output logic                                   saturated_o,
  output logic                                   is_last_o,
  input  mspd_pkg::cmd_t                         cmd_i,
  output mspd_pkg::status_t                      status_o,
  input  logic [((NDOF > 1) ? $clog2(NDOF) : 1)-1:0] mac_row_i,
  input  logic [((NDOF > 1) ? $clog2(NDOF) : 1)-1:0] mac_col_i
);
  import mspd_pkg::*;

  localparam int IDX_W = (NDOF > 1) ? $clog2(NDOF) : 1;
  localparam int MA_W  = (NDOF > 1) ? $clog2(NDOF * NDOF) : 1;

  // configuration
  logic [GAIN_W-1:0]  kp_q, kd_q;
  logic [DATA_W-1:0]  fps_q;
  logic [FRAME_W-1:0] final_q;
  logic [JCNT_W-1:0]  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KP_RESET;
      kd_q     <= KD_RESET;
      fps_q    <= FPS_RESET;
      final_q  <= FINAL_RESET;
      active_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KP:     kp_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KD:     kd_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_FPS:    fps_q    <= cfg_wdata_i;
        CFG_FINAL:  final_q  <= cfg_wdata_i[FRAME_W-1:0];
        CFG_ACTIVE: active_q <= cfg_wdata_i[JCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [1:0]        req_q;
  logic [5:0]        row_q, col_q;
  logic [DATA_W-1:0] mass_q, pos_q, vel_q, tgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q  <= req_type_i;
      row_q  <= row_index_i;
      col_q  <= col_index_i;
      mass_q <= mass_value_i;
      pos_q  <= joint_position_i;
      vel_q  <= joint_velocity_i;
      tgt_q  <= target_position_i;
    end
  end

  logic row_ok, col_ok;
  assign row_ok = ({1'b0, row_q} < 7'(NDOF));
  assign col_ok = ({1'b0, col_q} < 7'(NDOF));

  // memories
  logic [DATA_W-1:0] mass_mem [NDOF*NDOF];
  logic [DATA_W-1:0] pd_mem   [NDOF];
  logic [DATA_W-1:0] mass_rd_q, pd_rd_q;
  logic [MA_W-1:0]   mass_waddr, mass_raddr;
  sat_t              pd_sat;

  assign mass_waddr = MA_W'(row_q[IDX_W-1:0]) * MA_W'(NDOF) + MA_W'(col_q[IDX_W-1:0]);
  assign mass_raddr = MA_W'(mac_row_i) * MA_W'(NDOF) + MA_W'(mac_col_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mass_we) begin
      mass_mem[mass_waddr] <= mass_q;
    end
    if (cmd_i.mac_issue) begin
      mass_rd_q <= mass_mem[mass_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pd_we) begin
      pd_mem[row_q[IDX_W-1:0]] <= pd_sat.val;
    end
    if (cmd_i.mac_issue) begin
      pd_rd_q <= pd_mem[mac_col_i];
    end
  end

  logic [NDOF-1:0] clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else if (cmd_i.pd_we) begin
      clip_q[row_q[IDX_W-1:0]] <= pd_sat.clip;
    end
  end

  // shared multiplier
  logic [DATA_W-1:0]        step_q;
  logic signed [32:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_sh, p_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_FRAME: begin
        mul_a = $signed({1'b0, step_q});
        mul_b = $signed({1'b0, fps_q});
      end
      MUL_KP: begin
        mul_a = $signed({2'b00, kp_q});
        mul_b = $signed({tgt_q[31], tgt_q}) - $signed({pos_q[31], pos_q});
      end
      MUL_KD: begin
        mul_a = $signed({2'b00, kd_q});
        mul_b = -$signed({vel_q[31], vel_q});
      end
      default: begin
        mul_a = $signed({mass_rd_q[31], mass_rd_q});
        mul_b = $signed({pd_rd_q[31], pd_rd_q});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign prod_sh = prod_q >>> FRAC_BITS;

  // pd term
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_ld) begin
      p_q <= prod_sh;
    end
  end

  assign pd_sat = sat32(p_q + prod_sh);

  // frame
  logic [63:0]        frame_full;
  logic [FRAME_W-1:0] frame_q;

  assign frame_full = prod_q[63:0] >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_ld) begin
      frame_q <= (frame_full > 64'(final_q)) ? final_q : frame_full[FRAME_W-1:0];
    end
  end

  // multiply-accumulate pipeline
  logic                    v1_q, v2_q;
  logic signed [ACC_W-1:0] acc_q;
  sat_t                    tq_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_sh);
    end
  end

  assign tq_sat = sat32(PROD_W'(acc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.step_inc) begin
      step_q <= step_q + 32'd1;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      motion_frame_o <= frame_q;
      is_last_o      <= cmd_i.out_last;
      if (cmd_i.out_ack) begin
        joint_index_o <= '0;
        torque_o      <= '0;
        saturated_o   <= 1'b0;
      end else begin
        joint_index_o <= JIDX_W'(mac_row_i);
        torque_o      <= tq_sat.val;
        saturated_o   <= tq_sat.clip | clip_q[mac_row_i];
      end
    end
  end

  assign out_valid_o = out_valid_q;

  logic [JCNT_W-1:0] joint_count;
  always_comb begin
    if (active_q == '0) begin
      joint_count = 7'd1;
    end else if (active_q > 7'(NDOF)) begin
      joint_count = 7'(NDOF);
    end else begin
      joint_count = active_q;
    end
  end

  assign status_o.req_type    = req_q;
  assign status_o.row_ok      = row_ok;
  assign status_o.mass_ok     = row_ok && col_ok;
  assign status_o.mac_busy    = v1_q | v2_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.joint_count = joint_count;

  a_pd_row_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pd_we |-> row_ok)
    else $error("pd entry written for a joint out of range");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_no_clear_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_clr |-> !v2_q)
    else $error("accumulator cleared while a product is in flight");

endmodule

### src/mass_scaled_joint_pd_core.sv
// ----------------------------------------------------------------------------
// mass_scaled_joint_pd_core: mass-scaled joint PD controller
// Stores a mass matrix and per-joint PD terms; a compute request emits the
// matrix-vector product as saturated torques, one per active joint.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | req_type, row/col index, mass, joint state
//  rsp     | out | valid/ready    | joint_index, torque, frame, saturated, last
//  cfg     | in  | cfg_we_i       | cfg_index_i, cfg_wdata_i
//
//  Mass load or unused request: frame, clamp, acknowledge; joint load adds
//  P, D and sum steps. Compute: issue, drain and emit for each row; the single
//  multiplier runs one multiply-accumulate per cycle along each matrix row.
//  Reset clears control, configuration, step counter and pd clip flags;
//  the matrix and pd memories hold nothing valid until written.
//  A stalled output holds the sequencer in its emit or acknowledge state.
// ----------------------------------------------------------------------------
module mass_scaled_joint_pd_core #(
  parameter int NDOF      = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mspd_req_if.sink                       req,
  mspd_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [mspd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import mspd_pkg::*;

  localparam int IDX_W = (NDOF > 1) ? $clog2(NDOF) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] mac_row, mac_col;

  mspd_ctrl #(
    .NDOF (NDOF)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .mac_row_o  (mac_row),
    .mac_col_o  (mac_col)
  );

  mspd_dpath #(
    .NDOF      (NDOF)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req.req_type),
    .row_index_i       (req.row_index),
    .col_index_i       (req.col_index),
    .mass_value_i      (req.mass_value),
    .joint_position_i  (req.joint_position),
    .joint_velocity_i  (req.joint_velocity),
    .target_position_i (req.target_position),
    .out_valid_o       (rsp.valid),
    .out_ready_i       (rsp.ready),
    .joint_index_o     (rsp.joint_index),
    .torque_o          (rsp.torque),
    .motion_frame_o    (rsp.motion_frame),
    .saturated_o       (rsp.saturated),
    .is_last_o         (rsp.is_last),
    .cmd_i             (cmd),
    .status_o          (status),
    .mac_row_i         (mac_row),
    .mac_col_i         (mac_col)
  );

endmodule

### sim/tb_mass_scaled_joint_pd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mass_scaled_joint_pd_core: self-checking bench for the mass-scaled PD core
// Drives mass, joint and compute requests from a directed table and then
// from random sequences under several idle/stall patterns and register
// settings. Every response is compared with a local torque predictor or a table row.
// ----------------------------------------------------------------------------
module tb_mass_scaled_joint_pd_core;
  import mspd_pkg::*;

  localparam int          N_JOINTS    = 32;
  localparam int          Q_SHIFT     = 16;
  localparam int          QUIET_LIMIT = 20000;
  localparam logic [1:0]  REQ_SPARE   = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] mass;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] tgt;
  } job_t;

  typedef struct packed {
    logic [5:0]  joint;
    logic [31:0] torque;
    logic [19:0] frame;
    logic        sat;
    logic        last;
  } torque_rsp_t;

  typedef struct {
    job_t        job;
    bit          typed;
    torque_rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  mspd_req_if req ();
  mspd_rsp_if rsp ();

  mass_scaled_joint_pd_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [30:0]        kp_q, kd_q;
  logic [31:0]        fps_q;
  logic [19:0]        last_frame_q;
  logic [6:0]         active_q;
  logic signed [31:0] mass_mem [N_JOINTS][N_JOINTS];
  bit                 mass_written [N_JOINTS][N_JOINTS];
  logic signed [31:0] pd_mem [N_JOINTS];
  bit                 pd_written [N_JOINTS];
  bit                 pd_clipped [N_JOINTS];
  logic [31:0]        step_q;

  torque_rsp_t expected_q[$];
  int          n_errors, n_jobs, n_rsp, n_computes;
  int          send_idle_pct, recv_stall_pct;
  int          quiet_cycles = 0;

  function automatic int joints_in_use();
    if (active_q == 0) return 1;
    if (active_q > N_JOINTS) return N_JOINTS;
    return active_q;
  endfunction

  function automatic bit compute_is_safe();
    int n;
    n = joints_in_use();
    for (int i = 0; i < n; i++) begin
      if (!pd_written[i]) return 0;
      for (int j = 0; j < n; j++) if (!mass_written[i][j]) return 0;
    end
    return 1;
  endfunction

  function automatic logic signed [65:0] sext66(input logic [31:0] v);
    return $signed({{34{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x,
                                                  output bit clip);
    clip = 1'b1;
    if (x > 66'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -66'sh8000_0000) return 32'h8000_0000;
    clip = 1'b0;
    return x[31:0];
  endfunction

  // apply one accepted job to the predictor state and queue its responses
  task automatic predict_torques(input job_t j, input bit typed, input torque_rsp_t t_rsp);
    logic [63:0]        f64;
    logic [19:0]        frame;
    logic signed [65:0] err, p, d, acc;
    torque_rsp_t        r;
    bit                 clip;
    int                 n;
    f64 = (64'(step_q) * 64'(fps_q)) >> Q_SHIFT;
    frame = (f64 > 64'(last_frame_q)) ? last_frame_q : f64[19:0];
    r = '{joint: 6'd0, torque: 32'd0, frame: frame, sat: 1'b0, last: 1'b1};
    case (j.kind)
      REQ_MASS: begin
        if (j.row < N_JOINTS && j.col < N_JOINTS) begin
          mass_mem[j.row][j.col] = j.mass;
          mass_written[j.row][j.col] = 1;
        end
      end
      REQ_JOINT: begin
        if (j.row < N_JOINTS) begin
          err = sext66(j.pos) - sext66(j.tgt);
          p = (-($signed({35'd0, kp_q}) * err)) >>> Q_SHIFT;
          d = (-($signed({35'd0, kd_q}) * sext66(j.vel))) >>> Q_SHIFT;
          pd_mem[j.row] = clamp32(p + d, clip);
          pd_clipped[j.row] = clip;
          pd_written[j.row] = 1;
        end
      end
      REQ_COMPUTE: begin
        n = joints_in_use();
        for (int i = 0; i < n; i++) begin
          acc = '0;
          for (int k = 0; k < n; k++)
            acc += (sext66(mass_mem[i][k]) * sext66(pd_mem[k])) >>> Q_SHIFT;
          r.joint  = 6'(i);
          r.torque = clamp32(acc, clip);
          r.sat    = clip | pd_clipped[i];
          r.last   = (i == n - 1);
          expected_q.push_back(r);
        end
        step_q++;
        n_computes++;
      end
      default: ;
    endcase
    if (j.kind != REQ_COMPUTE) expected_q.push_back(typed ? t_rsp : r);
  endtask

  task automatic send_job(input job_t j, input bit typed = 0,
                          input torque_rsp_t t_rsp = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid           <= 1'b1;
    req.req_type        <= j.kind;
    req.row_index       <= j.row;
    req.col_index       <= j.col;
    req.mass_value      <= j.mass;
    req.joint_position  <= j.pos;
    req.joint_velocity  <= j.vel;
    req.target_position <= j.tgt;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_torques(j, typed, t_rsp);
    n_jobs++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KP:     kp_q = val[30:0];
      CFG_KD:     kd_q = val[30:0];
      CFG_FPS:    fps_q = val;
      CFG_FINAL:  last_frame_q = val[19:0];
      CFG_ACTIVE: active_q = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] kp, kd, fps, fin, act);
    wait_drained();
    write_reg(CFG_KP, kp);
    write_reg(CFG_KD, kd);
    write_reg(CFG_FPS, fps);
    write_reg(CFG_FINAL, fin);
    write_reg(CFG_ACTIVE, act);
  endtask

  function automatic logic [31:0] pick_value(input int span);
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5, 6, 7, 8, 9: return 32'($urandom);
      default: return 32'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic job_t random_job();
    job_t j;
    int   n, pick;
    n = joints_in_use();
    j.mass = pick_value(4 << Q_SHIFT);
    j.pos  = pick_value(8 << Q_SHIFT);
    j.vel  = pick_value(8 << Q_SHIFT);
    j.tgt  = pick_value(8 << Q_SHIFT);
    // mostly in-range indexes, now and then any index
    j.row  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
    j.col  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
    pick = $urandom_range(99);
    if (pick < 18 && compute_is_safe()) j.kind = REQ_COMPUTE;
    else if (pick < 22) j.kind = REQ_SPARE;
    else if (pick < 60) j.kind = REQ_MASS;
    else j.kind = REQ_JOINT;
    return j;
  endfunction

  // response side
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    torque_rsp_t got, want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{joint: rsp.joint_index, torque: rsp.torque, frame: rsp.motion_frame,
              sat: rsp.saturated, last: rsp.is_last};
      n_rsp++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected response: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.joint !== want.joint || got.torque !== want.torque ||
            got.frame !== want.frame || got.sat !== want.sat || got.last !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: joint %0d/%0d torque %h/%h frame %0d/%0d sat %b/%b last %b/%b",
                     want.joint, got.joint, want.torque, got.torque, want.frame, got.frame,
                     want.sat, got.sat, want.last, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout waiting for a transaction");
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic job_t mk(input logic [1:0] k, input int r, c,
                              input logic [31:0] m, q, v, t);
    return '{kind: k, row: 6'(r), col: 6'(c), mass: m, pos: q, vel: v, tgt: t};
  endfunction

  initial begin
    row_t        table_rows[$];
    torque_rsp_t ack0;
    int          modes_send[4] = '{0, 59, 0, 15};
    int          modes_recv[4] = '{0, 0, 59, 15};
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.req_type = '0;
    req.row_index = '0;
    req.col_index = '0;
    req.mass_value = '0;
    req.joint_position = '0;
    req.joint_velocity = '0;
    req.target_position = '0;
    rsp.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_errors = 0; n_jobs = 0; n_rsp = 0; n_computes = 0;
    kp_q = KP_RESET; kd_q = KD_RESET; fps_q = FPS_RESET;
    last_frame_q = FINAL_RESET; active_q = ACTIVE_RESET; step_q = '0;
    foreach (pd_clipped[i]) begin
      pd_clipped[i] = 0;
      pd_written[i] = 0;
    end
    foreach (mass_written[i, k]) mass_written[i][k] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two joints, reset gains, frame held at zero by final_frame
    write_reg(CFG_ACTIVE, 32'd2);
    ack0 = '{joint: 6'd0, torque: 32'd0, frame: 20'd0, sat: 1'b0, last: 1'b1};
    table_rows.push_back('{mk(REQ_MASS, 0, 0, 32'h0001_0000, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_MASS, 0, 1, 32'h7FFF_FFFF, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_MASS, 1, 0, 32'h8000_0000, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_MASS, 1, 1, 32'hFFFF_FFFF, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_MASS, 63, 0, 32'h1234_5678, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_MASS, 0, 32, 32'h1234_5678, 0, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_SPARE, 63, 63, '1, '1, '1, '1), 1, ack0});
    table_rows.push_back('{mk(REQ_JOINT, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000), 1, ack0});
    table_rows.push_back('{mk(REQ_JOINT, 1, 0, 0, 32'h0001_0000, 32'h0002_0000, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_JOINT, 63, 0, 0, 32'h7FFF_FFFF, 0, 0), 1, ack0});
    table_rows.push_back('{mk(REQ_COMPUTE, 0, 0, 0, 0, 0, 0), 0, ack0});
    table_rows.push_back('{mk(REQ_JOINT, 0, 0, 0, 32'hFFFF_8000, 32'h0000_4000,
                              32'h0000_8000), 0, ack0});
    table_rows.push_back('{mk(REQ_MASS, 0, 1, 32'h0002_0000, 0, 0, 0), 0, ack0});
    table_rows.push_back('{mk(REQ_MASS, 1, 0, 32'hFFFF_0000, 0, 0, 0), 0, ack0});
    table_rows.push_back('{mk(REQ_COMPUTE, 0, 0, 0, 0, 0, 0), 0, ack0});
    table_rows.push_back('{mk(REQ_JOINT, 1, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF), 0, ack0});
    table_rows.push_back('{mk(REQ_COMPUTE, 0, 0, 0, 0, 0, 0), 0, ack0});
    foreach (table_rows[i]) send_job(table_rows[i].job, table_rows[i].typed, table_rows[i].rsp);

    // random phases, each with its own idle pattern and register setting
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (ph)
        0: set_regs(32'($urandom_range(200 << 16)), 32'($urandom_range(20 << 16)),
                    32'h0001_8000, 32'd40, 32'd3);
        1: set_regs(32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h000F_FFFF, 32'd0);
        2: set_regs(32'h7FFF_FFFF, 32'd0, 32'd0, 32'($urandom_range(20'hFFFFF)), 32'd5);
        default: set_regs(32'($urandom), 32'($urandom), 32'($urandom),
                          32'($urandom), 32'd4);
      endcase
      send_idle_pct = modes_send[ph];
      recv_stall_pct = modes_recv[ph];
      for (int k = 0; k < 55; k++) begin
        if (k == 27) wait_drained();  // hold off until every response is back
        send_job(random_job());
      end
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (expected_q.size() != 0) n_errors++;
    $display("covered %0d requests (%0d torque computes), %0d responses checked",
             n_jobs, n_computes, n_rsp);
    $display("four idle patterns, gain/frame extremes, 1 to 5 active joints");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
